@@ hw/rtl/rcc_pkg.sv @@
`timescale 1ns / 1ps

package rcc_pkg;

    localparam int ID_W         = 10;
    localparam int LIT_W        = 11;
    localparam int VAR_W        = 10;
    localparam int LEN_W        = 5;
    localparam int CLEN_IDX_W   = 4;
    localparam int MAX_CLAUSE_LEN = 16;
    localparam int ANT_IDX_W    = 6;
    localparam int ANT_CNT_W    = 7;
    localparam int MAX_ANT      = 64;
    localparam int TRAIL_W      = 11;
    localparam int MAX_VARS     = 1024;
    localparam int MAX_CLAUSES  = 1024;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_ANT    = 3'd2;
    localparam logic [2:0] OP_CLAIM  = 3'd3;
    localparam logic [2:0] OP_RUN    = 3'd4;

    localparam logic [1:0] ST_VERIFIED = 2'd0;
    localparam logic [1:0] ST_NOT_VER  = 2'd1;
    localparam logic [1:0] ST_UNKNOWN  = 2'd2;
    localparam logic [1:0] ST_CAPACITY = 2'd3;

    // Variable assignment and literal value codes.
    localparam logic [1:0] VAL_NONE  = 2'd0;
    localparam logic [1:0] VAL_FALSE = 2'd1;
    localparam logic [1:0] VAL_TRUE  = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] len;
    } t_info;

    function automatic logic [1:0] lit_val(input logic [1:0] a, input logic pol);
        logic [1:0] v;
        if (a == VAL_NONE) begin
            v = VAL_NONE;
        end else if ((a == VAL_TRUE) == pol) begin
            v = VAL_TRUE;
        end else begin
            v = VAL_FALSE;
        end
        return v;
    endfunction

endpackage

@@ hw/rtl/rup_clause_checker_unit.sv @@
`timescale 1ns / 1ps

// Clause store and reverse unit propagation checker. Add literal and claim
// words are taken in the idle state; remove and antecedent words read the
// clause table first. The last literal of an added clause reads the table and,
// when the clause is kept, its literals are copied one by one into the literal
// memory. Unless an error is pending, a run walks every antecedent twice, then
// for every trail literal scans every antecedent clause literal by literal, and
// finally clears the assignment of every trail entry. After reset the block
// sweeps all 1024 entries of the clause table and the assignment memory before
// it takes its first word. Only one word is worked on at a time; a finished
// status waits in an output register.
module rup_clause_checker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [9:0]  i_clause_id,
    input  logic [10:0] i_literal,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status
);

    typedef enum logic [27:0] {
        S_CLR    = 28'h0000001,
        S_IDLE   = 28'h0000002,
        S_ADD_RD = 28'h0000004,
        S_ADD_WR = 28'h0000008,
        S_RM_RD  = 28'h0000010,
        S_AN_RD  = 28'h0000020,
        S_V_ANT  = 28'h0000040,
        S_V_INFO = 28'h0000080,
        S_V_CHK  = 28'h0000100,
        S_I_ANT  = 28'h0000200,
        S_I_INFO = 28'h0000400,
        S_I_CHK  = 28'h0000800,
        S_C_LIT  = 28'h0001000,
        S_AS_RD  = 28'h0002000,
        S_AS_EV  = 28'h0004000,
        S_P_TR   = 28'h0008000,
        S_P_TRD  = 28'h0010000,
        S_P_ANT  = 28'h0020000,
        S_P_INFO = 28'h0040000,
        S_P_CHK  = 28'h0080000,
        S_P_LIT  = 28'h0100000,
        S_P_LCHK = 28'h0200000,
        S_K_LIT  = 28'h0400000,
        S_K_LRD  = 28'h0800000,
        S_K_AEV  = 28'h1000000,
        S_W_TR   = 28'h2000000,
        S_W_CLR  = 28'h4000000,
        S_POST   = 28'h8000000
    } t_state;

    // Memories and their registered read data.
    rcc_pkg::t_info m_info [rcc_pkg::MAX_CLAUSES];
    logic [rcc_pkg::LIT_W-1:0] m_lits [rcc_pkg::MAX_CLAUSES * rcc_pkg::MAX_CLAUSE_LEN];
    logic [1:0] m_asg [rcc_pkg::MAX_VARS];
    logic [rcc_pkg::LIT_W-1:0] m_trail [rcc_pkg::MAX_VARS];
    logic [rcc_pkg::ID_W-1:0] m_ant [rcc_pkg::MAX_ANT];
    logic [rcc_pkg::LEN_W-1:0] m_cnt [rcc_pkg::MAX_ANT];

    rcc_pkg::t_info r_info_rd;
    logic [rcc_pkg::LIT_W-1:0] r_lits_rd;
    logic [1:0] r_asg_rd;
    logic [rcc_pkg::LIT_W-1:0] r_trail_rd;
    logic [rcc_pkg::ID_W-1:0] r_ant_rd;
    logic [rcc_pkg::LEN_W-1:0] r_cnt_rd;

    logic info_we, lits_we, asg_we, trail_we, ant_we, cnt_we;
    logic [rcc_pkg::ID_W-1:0] info_wa, info_ra;
    rcc_pkg::t_info info_wd;
    logic [rcc_pkg::ID_W+rcc_pkg::CLEN_IDX_W-1:0] lits_wa, lits_ra;
    logic [rcc_pkg::LIT_W-1:0] lits_wd;
    logic [rcc_pkg::VAR_W-1:0] asg_wa, asg_ra;
    logic [1:0] asg_wd;
    logic [rcc_pkg::VAR_W-1:0] trail_wa, trail_ra;
    logic [rcc_pkg::LIT_W-1:0] trail_wd;
    logic [rcc_pkg::ANT_IDX_W-1:0] ant_wa, ant_ra;
    logic [rcc_pkg::ID_W-1:0] ant_wd;
    logic [rcc_pkg::ANT_IDX_W-1:0] cnt_wa, cnt_ra;
    logic [rcc_pkg::LEN_W-1:0] cnt_wd;

    // Build and claim buffers.
    logic [rcc_pkg::LIT_W-1:0] r_bbuf [rcc_pkg::MAX_CLAUSE_LEN];
    logic [rcc_pkg::LIT_W-1:0] r_cbuf [rcc_pkg::MAX_CLAUSE_LEN];
    logic bbuf_we, cbuf_we;

    t_state r_state, n_state;
    logic [2:0] r_op, n_op;
    logic [rcc_pkg::ID_W-1:0] r_id, n_id;
    logic [rcc_pkg::LIT_W-1:0] r_lit, n_lit;
    logic [rcc_pkg::LEN_W-1:0] r_bnum, n_bnum;
    logic r_bover, n_bover;
    logic [rcc_pkg::LEN_W-1:0] r_cnum, n_cnum;
    logic [rcc_pkg::ANT_CNT_W-1:0] r_anum, n_anum;
    logic [1:0] r_err, n_err;
    logic [rcc_pkg::TRAIL_W-1:0] r_tn, n_tn;
    logic [rcc_pkg::TRAIL_W-1:0] r_q, n_q;
    logic [rcc_pkg::ANT_CNT_W-1:0] r_i, n_i;
    logic [rcc_pkg::LEN_W-1:0] r_j, n_j;
    logic [rcc_pkg::LEN_W-1:0] r_k, n_k;
    logic [rcc_pkg::LEN_W-1:0] r_c, n_c;
    logic [rcc_pkg::LEN_W-1:0] r_len, n_len;
    logic [rcc_pkg::LEN_W-1:0] r_cnt, n_cnt;
    logic [rcc_pkg::ID_W-1:0] r_cid, n_cid;
    logic [rcc_pkg::LIT_W-1:0] r_l, n_l;
    logic [rcc_pkg::LIT_W-1:0] r_alit, n_alit;
    logic r_ret_claim, n_ret_claim;
    logic [1:0] r_res, n_res;
    logic r_ov, n_ov;
    logic [1:0] r_status, n_status;

    logic in_acc;
    logic [1:0] cur_val;
    logic [rcc_pkg::LEN_W-1:0] dec_cnt;

    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_status    = r_status;

    always_ff @(posedge i_clk) begin
        if (info_we) begin
            m_info[info_wa] <= info_wd;
        end
        r_info_rd <= m_info[info_ra];
        if (lits_we) begin
            m_lits[lits_wa] <= lits_wd;
        end
        r_lits_rd <= m_lits[lits_ra];
        if (asg_we) begin
            m_asg[asg_wa] <= asg_wd;
        end
        r_asg_rd <= m_asg[asg_ra];
        if (trail_we) begin
            m_trail[trail_wa] <= trail_wd;
        end
        r_trail_rd <= m_trail[trail_ra];
        if (ant_we) begin
            m_ant[ant_wa] <= ant_wd;
        end
        r_ant_rd <= m_ant[ant_ra];
        if (cnt_we) begin
            m_cnt[cnt_wa] <= cnt_wd;
        end
        r_cnt_rd <= m_cnt[cnt_ra];
        if (bbuf_we) begin
            r_bbuf[r_bnum[rcc_pkg::CLEN_IDX_W-1:0]] <= i_literal;
        end
        if (cbuf_we) begin
            r_cbuf[r_cnum[rcc_pkg::CLEN_IDX_W-1:0]] <= i_literal;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op = r_op;
        n_id = r_id;
        n_lit = r_lit;
        n_bnum = r_bnum;
        n_bover = r_bover;
        n_cnum = r_cnum;
        n_anum = r_anum;
        n_err = r_err;
        n_tn = r_tn;
        n_q = r_q;
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        n_c = r_c;
        n_len = r_len;
        n_cnt = r_cnt;
        n_cid = r_cid;
        n_l = r_l;
        n_alit = r_alit;
        n_ret_claim = r_ret_claim;
        n_res = r_res;
        n_ov = r_ov && i_out_stall;
        n_status = r_status;

        info_we = 1'b0;  info_wa = r_id;  info_wd = '0;  info_ra = r_id;
        lits_we = 1'b0;  lits_wa = '0;    lits_wd = '0;  lits_ra = '0;
        asg_we = 1'b0;   asg_wa = '0;     asg_wd = rcc_pkg::VAL_NONE;
        asg_ra = r_alit[rcc_pkg::LIT_W-1:1];
        trail_we = 1'b0; trail_wa = r_tn[rcc_pkg::VAR_W-1:0]; trail_wd = r_alit;
        trail_ra = r_q[rcc_pkg::VAR_W-1:0];
        ant_we = 1'b0;   ant_wa = r_anum[rcc_pkg::ANT_IDX_W-1:0]; ant_wd = r_id;
        ant_ra = r_i[rcc_pkg::ANT_IDX_W-1:0];
        cnt_we = 1'b0;   cnt_wa = r_i[rcc_pkg::ANT_IDX_W-1:0]; cnt_wd = r_cnt;
        cnt_ra = r_i[rcc_pkg::ANT_IDX_W-1:0];
        bbuf_we = 1'b0;
        cbuf_we = 1'b0;

        cur_val = rcc_pkg::lit_val(r_asg_rd, r_alit[0]);
        dec_cnt = (r_cnt != '0) ? r_cnt - rcc_pkg::LEN_W'(1) : '0;

        unique case (r_state)
            S_CLR: begin
                info_we = 1'b1;
                info_wa = r_q[rcc_pkg::VAR_W-1:0];
                asg_we = 1'b1;
                asg_wa = r_q[rcc_pkg::VAR_W-1:0];
                n_q = r_q + 1'b1;
                if (r_q[rcc_pkg::VAR_W-1:0] == '1) begin
                    n_q = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                info_ra = i_clause_id;
                if (in_acc) begin
                    n_op = i_opcode;
                    n_id = i_clause_id;
                    n_lit = i_literal;
                    unique case (i_opcode)
                        rcc_pkg::OP_ADD: begin
                            if (r_bnum[rcc_pkg::LEN_W-1]) begin
                                n_bover = 1'b1;
                            end else begin
                                bbuf_we = 1'b1;
                                n_bnum = r_bnum + 1'b1;
                            end
                            if (i_last) begin
                                if (r_bover || r_bnum[rcc_pkg::LEN_W-1]) begin
                                    n_bnum = '0;
                                    n_bover = 1'b0;
                                    n_res = rcc_pkg::ST_CAPACITY;
                                    n_state = S_POST;
                                end else begin
                                    n_state = S_ADD_RD;
                                end
                            end
                        end
                        rcc_pkg::OP_REMOVE: n_state = S_RM_RD;
                        rcc_pkg::OP_ANT:    n_state = S_AN_RD;
                        rcc_pkg::OP_CLAIM: begin
                            if (r_cnum[rcc_pkg::LEN_W-1]) begin
                                if (r_err == 2'd0) begin
                                    n_err = rcc_pkg::ST_CAPACITY;
                                end
                            end else begin
                                cbuf_we = 1'b1;
                                n_cnum = r_cnum + 1'b1;
                            end
                        end
                        rcc_pkg::OP_RUN: begin
                            n_i = '0;
                            n_q = '0;
                            if (r_err != 2'd0) begin
                                n_res = r_err;
                                n_state = S_W_TR;
                            end else begin
                                n_state = S_V_ANT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ADD_RD: begin
                if (r_info_rd.valid) begin
                    n_bnum = '0;
                    n_state = S_IDLE;
                end else begin
                    n_j = '0;
                    n_state = S_ADD_WR;
                end
            end
            S_ADD_WR: begin
                lits_we = 1'b1;
                lits_wa = {r_id, r_j[rcc_pkg::CLEN_IDX_W-1:0]};
                lits_wd = r_bbuf[r_j[rcc_pkg::CLEN_IDX_W-1:0]];
                n_j = r_j + 1'b1;
                if (n_j == r_bnum) begin
                    info_we = 1'b1;
                    info_wd = '{valid: 1'b1, len: r_bnum};
                    n_bnum = '0;
                    n_state = S_IDLE;
                end
            end
            S_RM_RD: begin
                if (!r_info_rd.valid) begin
                    n_res = rcc_pkg::ST_UNKNOWN;
                    n_state = S_POST;
                end else begin
                    info_we = 1'b1;
                    info_wd = '{valid: 1'b0, len: r_info_rd.len};
                    n_state = S_IDLE;
                end
            end
            S_AN_RD: begin
                if (!r_info_rd.valid) begin
                    if (r_err == 2'd0) begin
                        n_err = rcc_pkg::ST_UNKNOWN;
                    end
                end else if (r_anum[rcc_pkg::ANT_CNT_W-1]) begin
                    if (r_err == 2'd0) begin
                        n_err = rcc_pkg::ST_CAPACITY;
                    end
                end else begin
                    ant_we = 1'b1;
                    n_anum = r_anum + 1'b1;
                end
                n_state = S_IDLE;
            end
            // Every listed antecedent must still be in the store.
            S_V_ANT: begin
                if (r_i == r_anum) begin
                    n_i = '0;
                    n_state = S_I_ANT;
                end else begin
                    n_state = S_V_INFO;
                end
            end
            S_V_INFO: begin
                info_ra = r_ant_rd;
                n_state = S_V_CHK;
            end
            S_V_CHK: begin
                if (!r_info_rd.valid) begin
                    n_res = rcc_pkg::ST_UNKNOWN;
                    n_state = S_W_TR;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_V_ANT;
                end
            end
            // Unit antecedents are assigned, the others get their counts.
            S_I_ANT: begin
                if (r_i == r_anum) begin
                    n_c = '0;
                    n_state = S_C_LIT;
                end else begin
                    n_state = S_I_INFO;
                end
            end
            S_I_INFO: begin
                info_ra = r_ant_rd;
                lits_ra = {r_ant_rd, rcc_pkg::CLEN_IDX_W'(0)};
                n_state = S_I_CHK;
            end
            S_I_CHK: begin
                if (r_info_rd.len == rcc_pkg::LEN_W'(1)) begin
                    n_alit = r_lits_rd;
                    n_ret_claim = 1'b0;
                    n_state = S_AS_RD;
                end else begin
                    cnt_we = 1'b1;
                    cnt_wd = r_info_rd.len;
                    n_i = r_i + 1'b1;
                    n_state = S_I_ANT;
                end
            end
            S_C_LIT: begin
                if (r_c == r_cnum) begin
                    n_q = '0;
                    n_state = S_P_TR;
                end else begin
                    n_alit = r_cbuf[r_c[rcc_pkg::CLEN_IDX_W-1:0]] ^ rcc_pkg::LIT_W'(1);
                    n_ret_claim = 1'b1;
                    n_state = S_AS_RD;
                end
            end
            S_AS_RD: begin
                n_state = S_AS_EV;
            end
            S_AS_EV: begin
                if (cur_val == rcc_pkg::VAL_FALSE) begin
                    n_res = rcc_pkg::ST_VERIFIED;
                    n_q = '0;
                    n_state = S_W_TR;
                end else begin
                    if (cur_val == rcc_pkg::VAL_NONE && !r_tn[rcc_pkg::TRAIL_W-1]) begin
                        asg_we = 1'b1;
                        asg_wa = r_alit[rcc_pkg::LIT_W-1:1];
                        asg_wd = r_alit[0] ? rcc_pkg::VAL_TRUE : rcc_pkg::VAL_FALSE;
                        trail_we = 1'b1;
                        n_tn = r_tn + 1'b1;
                    end
                    if (r_ret_claim) begin
                        n_c = r_c + 1'b1;
                        n_state = S_C_LIT;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_state = S_I_ANT;
                    end
                end
            end
            // Propagation: every trail literal against every antecedent.
            S_P_TR: begin
                if (r_q == r_tn) begin
                    n_res = rcc_pkg::ST_NOT_VER;
                    n_q = '0;
                    n_state = S_W_TR;
                end else begin
                    n_state = S_P_TRD;
                end
            end
            S_P_TRD: begin
                n_l = r_trail_rd;
                n_i = '0;
                n_state = S_P_ANT;
            end
            S_P_ANT: begin
                if (r_i == r_anum) begin
                    n_q = r_q + 1'b1;
                    n_state = S_P_TR;
                end else begin
                    n_state = S_P_INFO;
                end
            end
            S_P_INFO: begin
                info_ra = r_ant_rd;
                n_cid = r_ant_rd;
                n_cnt = r_cnt_rd;
                n_state = S_P_CHK;
            end
            S_P_CHK: begin
                n_len = r_info_rd.len;
                if (r_info_rd.len < rcc_pkg::LEN_W'(2)) begin
                    n_i = r_i + 1'b1;
                    n_state = S_P_ANT;
                end else begin
                    n_j = '0;
                    n_state = S_P_LIT;
                end
            end
            S_P_LIT: begin
                lits_ra = {r_cid, r_j[rcc_pkg::CLEN_IDX_W-1:0]};
                if (r_j == r_len) begin
                    n_i = r_i + 1'b1;
                    n_state = S_P_ANT;
                end else begin
                    n_state = S_P_LCHK;
                end
            end
            S_P_LCHK: begin
                if ((r_lits_rd ^ rcc_pkg::LIT_W'(1)) != r_l) begin
                    n_j = r_j + 1'b1;
                    n_state = S_P_LIT;
                end else begin
                    n_cnt = dec_cnt;
                    cnt_we = 1'b1;
                    cnt_wd = dec_cnt;
                    if (dec_cnt == '0) begin
                        n_res = rcc_pkg::ST_VERIFIED;
                        n_q = '0;
                        n_state = S_W_TR;
                    end else if (dec_cnt == rcc_pkg::LEN_W'(1)) begin
                        n_k = '0;
                        n_state = S_K_LIT;
                    end else begin
                        n_j = r_j + 1'b1;
                        n_state = S_P_LIT;
                    end
                end
            end
            // Find the first literal of the clause that is not false.
            S_K_LIT: begin
                lits_ra = {r_cid, r_k[rcc_pkg::CLEN_IDX_W-1:0]};
                if (r_k == r_len) begin
                    n_j = r_j + 1'b1;
                    n_state = S_P_LIT;
                end else begin
                    n_state = S_K_LRD;
                end
            end
            S_K_LRD: begin
                n_alit = r_lits_rd;
                asg_ra = r_lits_rd[rcc_pkg::LIT_W-1:1];
                n_state = S_K_AEV;
            end
            S_K_AEV: begin
                if (cur_val != rcc_pkg::VAL_FALSE) begin
                    if (cur_val == rcc_pkg::VAL_NONE && !r_tn[rcc_pkg::TRAIL_W-1]) begin
                        asg_we = 1'b1;
                        asg_wa = r_alit[rcc_pkg::LIT_W-1:1];
                        asg_wd = r_alit[0] ? rcc_pkg::VAL_TRUE : rcc_pkg::VAL_FALSE;
                        trail_we = 1'b1;
                        n_tn = r_tn + 1'b1;
                    end
                    n_j = r_j + 1'b1;
                    n_state = S_P_LIT;
                end else begin
                    n_k = r_k + 1'b1;
                    n_state = S_K_LIT;
                end
            end
            // Unassign every trail variable, then drop the check.
            S_W_TR: begin
                if (r_q == r_tn) begin
                    n_tn = '0;
                    n_anum = '0;
                    n_cnum = '0;
                    n_err = '0;
                    n_state = S_POST;
                end else begin
                    n_state = S_W_CLR;
                end
            end
            S_W_CLR: begin
                asg_we = 1'b1;
                asg_wa = r_trail_rd[rcc_pkg::LIT_W-1:1];
                n_q = r_q + 1'b1;
                n_state = S_W_TR;
            end
            S_POST: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov = 1'b1;
                    n_status = r_res;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_bnum <= '0;
            r_bover <= 1'b0;
            r_cnum <= '0;
            r_anum <= '0;
            r_err <= '0;
            r_tn <= '0;
            r_q <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bnum <= n_bnum;
            r_bover <= n_bover;
            r_cnum <= n_cnum;
            r_anum <= n_anum;
            r_err <= n_err;
            r_tn <= n_tn;
            r_q <= n_q;
            r_ov <= n_ov;
        end
        r_op <= n_op;
        r_id <= n_id;
        r_lit <= n_lit;
        r_i <= n_i;
        r_j <= n_j;
        r_k <= n_k;
        r_c <= n_c;
        r_len <= n_len;
        r_cnt <= n_cnt;
        r_cid <= n_cid;
        r_l <= n_l;
        r_alit <= n_alit;
        r_ret_claim <= n_ret_claim;
        r_res <= n_res;
        r_status <= n_status;
    end

`ifndef SYNTH
    a_trail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tn <= rcc_pkg::TRAIL_W'(rcc_pkg::MAX_VARS))
        else $error("trail count beyond variable count");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_tn == '0))
        else $error("assignment left over between checks");

    a_buf_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bnum <= rcc_pkg::LEN_W'(rcc_pkg::MAX_CLAUSE_LEN))
        && (r_cnum <= rcc_pkg::LEN_W'(rcc_pkg::MAX_CLAUSE_LEN))
        && (r_anum <= rcc_pkg::ANT_CNT_W'(rcc_pkg::MAX_ANT)))
        else $error("buffer count out of range");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_W_TR && r_state == S_POST) |-> (r_anum == '0 && r_err == '0))
        else $error("check not cleared after run");
`endif

endmodule

@@ tb/rup_clause_checker_unit_tb.sv @@
`timescale 1ns / 1ps

module rup_clause_checker_unit_tb;

    localparam int IDLE_LIMIT  = 2000000;
    localparam int RANDOM_WORDS = 1350;

    // Tracks the clause store and the pending check, and queues the status
    // each accepted word is due to produce.
    class rup_status_board;
        bit               clause_ok [1024];
        int               clause_len [1024];
        logic [10:0]      clause_lit [1024][16];
        logic [1:0]       var_asg [1024];
        logic [10:0]      trail [1024];
        int               trail_n;
        logic [9:0]       ant_ids [64];
        int               ant_cnt [64];
        int               ant_n;
        logic [1:0]       chk_err;
        logic [10:0]      claim [16];
        int               claim_n;
        logic [10:0]      build [16];
        int               build_n;
        bit               build_over;
        logic [1:0]       status_q [$];
        int               errors;

        function new();
            foreach (clause_ok[i]) clause_ok[i] = 0;
            foreach (var_asg[i]) var_asg[i] = rcc_pkg::VAL_NONE;
            trail_n = 0; ant_n = 0; claim_n = 0; build_n = 0;
            build_over = 0; chk_err = 0; errors = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function logic [1:0] value_of(logic [10:0] l);
            logic [1:0] a;
            a = var_asg[l[10:1]];
            if (a == rcc_pkg::VAL_NONE) return rcc_pkg::VAL_NONE;
            return ((a == rcc_pkg::VAL_TRUE) == l[0]) ? rcc_pkg::VAL_TRUE
                                                      : rcc_pkg::VAL_FALSE;
        endfunction

        // Returns 0 when the literal is already false.
        function bit make_true(logic [10:0] l);
            logic [1:0] v;
            v = value_of(l);
            if (v == rcc_pkg::VAL_FALSE) return 0;
            if (v == rcc_pkg::VAL_NONE && trail_n < 1024) begin
                var_asg[l[10:1]] = l[0] ? rcc_pkg::VAL_TRUE : rcc_pkg::VAL_FALSE;
                trail[trail_n++] = l;
            end
            return 1;
        endfunction

        function bit propagate_conflict();
            int id, len;
            logic [10:0] l;
            for (int q = 0; q < trail_n; q++) begin
                l = trail[q];
                for (int i = 0; i < ant_n; i++) begin
                    id = ant_ids[i];
                    len = clause_len[id];
                    if (len < 2) continue;
                    for (int j = 0; j < len; j++) begin
                        if ((clause_lit[id][j] ^ 11'd1) != l) continue;
                        if (ant_cnt[i] > 0) ant_cnt[i]--;
                        if (ant_cnt[i] == 0) return 1;
                        if (ant_cnt[i] == 1) begin
                            for (int k = 0; k < len; k++) begin
                                if (value_of(clause_lit[id][k]) != rcc_pkg::VAL_FALSE) begin
                                    void'(make_true(clause_lit[id][k]));
                                    break;
                                end
                            end
                        end
                    end
                end
            end
            return 0;
        endfunction

        function logic [1:0] run_status();
            bit conflict;
            int id;
            conflict = 0;
            if (chk_err != 0) return chk_err;
            for (int i = 0; i < ant_n; i++)
                if (!clause_ok[ant_ids[i]]) return rcc_pkg::ST_UNKNOWN;
            for (int i = 0; i < ant_n && !conflict; i++) begin
                id = ant_ids[i];
                if (clause_len[id] == 1) begin
                    if (!make_true(clause_lit[id][0])) conflict = 1;
                end else begin
                    ant_cnt[i] = clause_len[id];
                end
            end
            for (int i = 0; i < claim_n && !conflict; i++)
                if (!make_true(claim[i] ^ 11'd1)) conflict = 1;
            if (!conflict) conflict = propagate_conflict();
            return conflict ? rcc_pkg::ST_VERIFIED : rcc_pkg::ST_NOT_VER;
        endfunction

        function void note_word(logic [2:0] op, logic [9:0] id, logic [10:0] lit,
                                logic last);
            case (op)
                rcc_pkg::OP_ADD: begin
                    if (build_n >= rcc_pkg::MAX_CLAUSE_LEN) build_over = 1;
                    else build[build_n++] = lit;
                    if (last) begin
                        if (build_over) begin
                            status_q.push_back(rcc_pkg::ST_CAPACITY);
                        end else if (!clause_ok[id]) begin
                            clause_ok[id] = 1;
                            clause_len[id] = build_n;
                            for (int i = 0; i < build_n; i++) clause_lit[id][i] = build[i];
                        end
                        build_n = 0;
                        build_over = 0;
                    end
                end
                rcc_pkg::OP_REMOVE: begin
                    if (!clause_ok[id]) status_q.push_back(rcc_pkg::ST_UNKNOWN);
                    else clause_ok[id] = 0;
                end
                rcc_pkg::OP_ANT: begin
                    if (!clause_ok[id]) begin
                        if (chk_err == 0) chk_err = rcc_pkg::ST_UNKNOWN;
                    end else if (ant_n >= rcc_pkg::MAX_ANT) begin
                        if (chk_err == 0) chk_err = rcc_pkg::ST_CAPACITY;
                    end else begin
                        ant_ids[ant_n++] = id;
                    end
                end
                rcc_pkg::OP_CLAIM: begin
                    if (claim_n >= rcc_pkg::MAX_CLAUSE_LEN) begin
                        if (chk_err == 0) chk_err = rcc_pkg::ST_CAPACITY;
                    end else begin
                        claim[claim_n++] = lit;
                    end
                end
                rcc_pkg::OP_RUN: begin
                    status_q.push_back(run_status());
                    for (int i = 0; i < trail_n; i++)
                        var_asg[trail[i][10:1]] = rcc_pkg::VAL_NONE;
                    trail_n = 0; ant_n = 0; claim_n = 0; chk_err = 0;
                    foreach (ant_cnt[i]) ant_cnt[i] = 0;
                end
                default: ;
            endcase
        endfunction

        task check_status(logic [1:0] st);
            logic [1:0] want;
            if (status_q.size() == 0) begin
                report($sformatf("status %0d with nothing pending", st));
            end else begin
                want = status_q.pop_front();
                if (st !== want) report($sformatf("status %0d, predicted %0d", st, want));
            end
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    logic [2:0]  i_opcode = 0;
    logic [9:0]  i_clause_id = 0;
    logic [10:0] i_literal = 0;
    logic        i_last = 0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    logic [1:0]  o_status;

    rup_clause_checker_unit i_dut (.*);

    rup_status_board board = new();
    int idle_cycles = 0;
    int burst_left = 0;
    int word_count = 0;
    int stall_mode = 0;
    int stall_hold = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("rup_clause_checker_unit verification failed");
                $finish;
            end
            if (o_out_valid && !i_out_stall) board.check_status(o_status);
        end
        if (stall_hold == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_hold <= $urandom_range(64, 256);
        end else begin
            stall_hold <= stall_hold - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 0;
            1: i_out_stall <= $urandom_range(0, 1);
            default: i_out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Called just after a rising edge; returns just after the edge that took the word.
    task send_word(logic [2:0] op, logic [9:0] id, logic [10:0] lit, logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            if (gap > 0) begin
                i_in_valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_in_valid <= 1;
        i_opcode <= op;
        i_clause_id <= id;
        i_literal <= lit;
        i_last <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_word(op, id, lit, last);
        if (op <= rcc_pkg::OP_RUN) word_count++;
    endtask

    task send_clause(logic [9:0] id, int len, int var_hi);
        for (int k = 0; k < len; k++)
            send_word(rcc_pkg::OP_ADD, id, {10'($urandom_range(0, var_hi)), 1'($urandom)},
                      k == len - 1);
    endtask

    function logic [9:0] pick_valid_id();
        logic [9:0] ids [$];
        for (int i = 0; i < 32; i++) if (board.clause_ok[i]) ids.push_back(10'(i));
        if (board.clause_ok[1023]) ids.push_back(10'd1023);
        if (ids.size() == 0) return 10'($urandom_range(0, 31));
        return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    task random_check();
        int n;
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++)
            send_word(rcc_pkg::OP_ANT, pick_valid_id(), 11'($urandom), 1'($urandom));
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
            send_word(rcc_pkg::OP_CLAIM, 10'($urandom),
                      {10'($urandom_range(0, 7)), 1'($urandom)}, 1'($urandom));
        send_word(rcc_pkg::OP_RUN, 10'($urandom), 11'($urandom), 1'($urandom));
    endtask

    task wait_drained();
        i_in_valid <= 0;
        burst_left = 0;
        while (board.status_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        int pick;
        bit paused;
        paused = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes, a duplicate add, overflows, unknown ids, unused opcodes.
        send_word(rcc_pkg::OP_ADD, 10'd0, 11'd1, 1'b1);
        send_clause(10'd1023, 15, 1023);
        send_word(rcc_pkg::OP_ADD, 10'd1023, 11'd2047, 1'b1);
        send_word(rcc_pkg::OP_ADD, 10'd0, 11'd0, 1'b1);
        send_clause(10'd5, 17, 7);
        send_word(rcc_pkg::OP_ADD, 10'd2, 11'd0, 1'b0);
        send_word(rcc_pkg::OP_ADD, 10'd2, 11'd3, 1'b1);
        send_word(rcc_pkg::OP_ANT, 10'd0, 11'd0, 1'b0);
        send_word(rcc_pkg::OP_ANT, 10'd2, 11'd0, 1'b0);
        send_word(rcc_pkg::OP_ANT, 10'd2, 11'd0, 1'b0);
        send_word(rcc_pkg::OP_RUN, 10'd0, 11'd0, 1'b0);
        send_word(rcc_pkg::OP_ANT, 10'd2, 11'd0, 1'b0);
        send_word(rcc_pkg::OP_CLAIM, 10'd0, 11'd2, 1'b0);
        send_word(rcc_pkg::OP_RUN, 10'd0, 11'd0, 1'b0);
        send_word(rcc_pkg::OP_ANT, 10'd7, 11'd0, 1'b0);
        send_word(rcc_pkg::OP_RUN, 10'd0, 11'd0, 1'b0);
        send_word(rcc_pkg::OP_REMOVE, 10'd1023, 11'd0, 1'b0);
        send_word(rcc_pkg::OP_REMOVE, 10'd1023, 11'd2047, 1'b1);
        send_word(3'd5, 10'd1023, 11'd2047, 1'b1);
        send_word(3'd7, 10'd0, 11'd0, 1'b0);
        send_word(rcc_pkg::OP_RUN, 10'd0, 11'd0, 1'b0);

        while (word_count < RANDOM_WORDS + 25) begin
            if (!paused && word_count > 700) begin
                wait_drained();
                paused = 1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                random_check();
            end else if (pick < 75) begin
                send_clause(($urandom_range(0, 19) == 0) ? 10'($urandom)
                            : 10'($urandom_range(0, 31)), $urandom_range(1, 5), 7);
            end else if (pick < 80) begin
                send_clause(10'($urandom), ($urandom_range(0, 1)) ? 16 : 17, 1023);
            end else if (pick < 88) begin
                send_word(rcc_pkg::OP_REMOVE, ($urandom_range(0, 9) == 0) ? 10'($urandom)
                          : 10'($urandom_range(0, 31)), 11'($urandom), 1'($urandom));
            end else if (pick < 93) begin
                send_word(3'($urandom_range(5, 7)), 10'($urandom), 11'($urandom), 1'($urandom));
            end else if (pick < 97) begin
                // Broken check: a stray id and wide claim literals.
                send_word(rcc_pkg::OP_ANT, 10'($urandom), 11'($urandom), 1'($urandom));
                for (int i = 0; i < $urandom_range(1, 17); i++)
                    send_word(rcc_pkg::OP_CLAIM, 10'($urandom), 11'($urandom), 1'($urandom));
                send_word(rcc_pkg::OP_RUN, 10'($urandom), 11'($urandom), 1'($urandom));
            end else begin
                // More antecedents than the list holds.
                for (int i = 0; i < 65; i++)
                    send_word(rcc_pkg::OP_ANT, pick_valid_id(), 11'd0, 1'b0);
                send_word(rcc_pkg::OP_RUN, 10'd0, 11'd0, 1'b0);
            end
        end

        wait_drained();
        repeat (300) @(posedge i_clk);
        if (board.errors == 0 && board.status_q.size() == 0) begin
            $display("rup_clause_checker_unit verification clean");
        end else begin
            $display("rup_clause_checker_unit verification failed");
        end
        $finish;
    end

endmodule
